FILE: src/sch_pkg.sv
package sch_pkg;

	localparam int unsigned DEF_MAX_COLS   = 64;
	localparam int unsigned DEF_MAX_ROWS   = 64;
	localparam int unsigned DEF_NUM_CODES  = 16;
	localparam int unsigned DEF_COUNT_BITS = 16;

	// Field widths fixed by the interface.
	localparam int unsigned COORD_W   = 24;
	localparam int unsigned SPACING_W = 16;
	localparam int unsigned DIM_W     = 7;
	localparam int unsigned CODE_W    = 4;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CSUM_W    = 28;
	localparam int unsigned CMAX_W    = 16;
	localparam int unsigned TSUM_W    = 32;
	localparam int unsigned PIX_W     = 13;
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned PDATA_W   = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_SPACING_X   = 3'd2,
		REG_SPACING_Y   = 3'd3,
		REG_WIDTH_USED  = 3'd4,
		REG_HEIGHT_USED = 3'd5
	} reg_idx_t;

	// Status handed back by a serial divider.
	typedef struct packed {
		logic                 done;
		logic [COORD_W-1:0]   quotient;
	} div_res_t;

endpackage

FILE: src/sch_div.sv
module sch_div #(
	parameter int unsigned DW = 24,
	parameter int unsigned VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             ge;
	logic [VW-1:0]    rem_n;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign rem_n = ge ? VW'(trial - {1'b0, divisor}) : VW'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/spatial_code_histogram_unit.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   op, point_x, point_y, code
// out       out_valid / out_ready kind, accepted, row, col, report_code, code_sum,
//                                 code_max, total_sum, pixel_count, last
// cfg       APB write/read        paddr, pwdata, prdata
// An insert runs the two parallel bit-serial dividers, then one bin check, one memory read
// and one write-back, and then offers its ack.
// A rejected insert skips the memory read and write-back and offers its ack after the bin check.
// A report reads each of the width*height*NUM_CODES used bins, one per cycle, then passes
// one drain state and presents NUM_CODES lines; a zero width or height skips straight to them.
// After reset a clearing pass writes zero to every bin, one per cycle
// (MAX_ROWS*MAX_COLS*NUM_CODES bins, 65536 by default); no item is taken then.
// One item is in work at a time; a stalled output holds the block.
module spatial_code_histogram_unit #(
	parameter int unsigned MAX_COLS   = sch_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS   = sch_pkg::DEF_MAX_ROWS,
	parameter int unsigned NUM_CODES  = sch_pkg::DEF_NUM_CODES,
	parameter int unsigned COUNT_BITS = sch_pkg::DEF_COUNT_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [sch_pkg::PADDR_W-1:0]            paddr,
	input  logic [sch_pkg::PDATA_W-1:0]            pwdata,
	output logic [sch_pkg::PDATA_W-1:0]            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic signed [sch_pkg::COORD_W-1:0]     point_x,
	input  logic signed [sch_pkg::COORD_W-1:0]     point_y,
	input  logic [sch_pkg::CODE_W-1:0]             code,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   kind,
	output logic                                   accepted,
	output logic [sch_pkg::IDX_W-1:0]              row,
	output logic [sch_pkg::IDX_W-1:0]              col,
	output logic [sch_pkg::CODE_W-1:0]             report_code,
	output logic [sch_pkg::CSUM_W-1:0]             code_sum,
	output logic [sch_pkg::CMAX_W-1:0]             code_max,
	output logic [sch_pkg::TSUM_W-1:0]             total_sum,
	output logic [sch_pkg::PIX_W-1:0]              pixel_count,
	output logic                                   last
);
	import sch_pkg::*;

	localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS * NUM_CODES;
	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW      = $clog2(MAX_COLS + 1);
	localparam int unsigned RW      = $clog2(MAX_ROWS + 1);
	localparam int unsigned KW      = $clog2(NUM_CODES + 1);
	localparam int unsigned CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned RIW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned SW      = 28;
	localparam int unsigned ROW_STRIDE = MAX_COLS * NUM_CODES;
	localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_DIV   = 10'b0000000100,
		ST_CHK   = 10'b0000001000,
		ST_RD    = 10'b0000010000,
		ST_WR    = 10'b0000100000,
		ST_ACK   = 10'b0001000000,
		ST_SWEEP = 10'b0010000000,
		ST_DRAIN = 10'b0100000000,
		ST_REP   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COORD_W-1:0]   origin_x_q, origin_y_q;
	logic [SPACING_W-1:0] spacing_x_q, spacing_y_q;
	logic [DIM_W-1:0]     width_used_q, height_used_q;
	logic                 cfg_we;
	reg_idx_t             cfg_idx;

	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			spacing_x_q   <= SPACING_W'(256);
			spacing_y_q   <= SPACING_W'(256);
			width_used_q  <= DIM_W'(64);
			height_used_q <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ORIGIN_X:    origin_x_q    <= pwdata[COORD_W-1:0];
				REG_ORIGIN_Y:    origin_y_q    <= pwdata[COORD_W-1:0];
				REG_SPACING_X:   spacing_x_q   <= pwdata[SPACING_W-1:0];
				REG_SPACING_Y:   spacing_y_q   <= pwdata[SPACING_W-1:0];
				REG_WIDTH_USED:  width_used_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT_USED: height_used_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ORIGIN_X:    prdata = PDATA_W'(origin_x_q);
			REG_ORIGIN_Y:    prdata = PDATA_W'(origin_y_q);
			REG_SPACING_X:   prdata = PDATA_W'(spacing_x_q);
			REG_SPACING_Y:   prdata = PDATA_W'(spacing_y_q);
			REG_WIDTH_USED:  prdata = PDATA_W'(width_used_q);
			REG_HEIGHT_USED: prdata = PDATA_W'(height_used_q);
			default:         prdata = '0;
		endcase
	end

	// Used grid size, clamped to the built size.
	logic [CW-1:0] w_eff;
	logic [RW-1:0] h_eff;

	assign w_eff = (32'(width_used_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(width_used_q);
	assign h_eff = (32'(height_used_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(height_used_q);

	// Insert front end: offsets and dividers.
	logic                 acc_in;
	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0]   mag_x, mag_y;
	logic                 neg_x_q, neg_y_q;
	logic [CODE_W-1:0]    code_q;
	logic                 div_start;
	div_res_t             res_x, res_y;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc_in    = in_valid && in_ready;
	assign div_start = acc_in && (op == OP_INSERT);

	assign dx    = $signed({point_x[COORD_W-1], point_x}) -
	               $signed({origin_x_q[COORD_W-1], origin_x_q});
	assign dy    = $signed({point_y[COORD_W-1], point_y}) -
	               $signed({origin_y_q[COORD_W-1], origin_y_q});
	assign mag_x = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
	assign mag_y = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);

	sch_div #(.DW(COORD_W), .VW(SPACING_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_x),
		.divisor  (spacing_x_q),
		.done     (res_x.done),
		.quotient (res_x.quotient)
	);

	sch_div #(.DW(COORD_W), .VW(SPACING_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_y),
		.divisor  (spacing_y_q),
		.done     (res_y.done),
		.quotient (res_y.quotient)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_x_q <= dx[COORD_W];
			neg_y_q <= dy[COORD_W];
			code_q  <= code;
		end
	end

	// Bin check on the signed quotients.
	logic signed [SW-1:0] qx_s, qy_s, h_s, w_s, row0_s, row_s;
	logic                 chk_ok;
	logic                 ok_q;
	logic [RIW-1:0]       row_q;
	logic [CIW-1:0]       col_q;

	always_comb begin
		qx_s   = neg_x_q ? -$signed(SW'(res_x.quotient)) : $signed(SW'(res_x.quotient));
		qy_s   = neg_y_q ? -$signed(SW'(res_y.quotient)) : $signed(SW'(res_y.quotient));
		h_s    = $signed(SW'(h_eff));
		w_s    = $signed(SW'(w_eff));
		row0_s = h_s - qy_s;
		row_s  = (row0_s > 0) ? row0_s - SW'(1) : row0_s;
		chk_ok = (spacing_x_q != '0) && (spacing_y_q != '0) &&
		         (32'(code_q) < NUM_CODES) &&
		         (qx_s >= 0) && (qx_s < w_s) && (row_s >= 0) && (row_s < h_s);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHK) begin
			ok_q  <= chk_ok;
			row_q <= RIW'(row_s);
			col_q <= CIW'(qx_s);
		end
	end

	// Bin memory.
	logic [COUNT_BITS-1:0] bin_mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [AW-1:0]         ins_addr, rd_addr, wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  wr_en;
	logic [AW-1:0]         clr_q;

	assign ins_addr = AW'((32'(row_q) * MAX_COLS + 32'(col_q)) * NUM_CODES + 32'(code_q));

	// Report sweep counters.
	logic [KW-1:0] k_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [AW-1:0] pix_base_q, row_base_q;
	logic          sweep_last;
	logic          v_s1;

	assign sweep_last = (32'(k_q) == NUM_CODES - 1) && (c_q == CW'(w_eff - 1'b1)) &&
	                    (r_q == RW'(h_eff - 1'b1));

	assign rd_addr = (state_q == ST_SWEEP) ? AW'(pix_base_q + AW'(k_q)) : ins_addr;
	assign wr_en   = (state_q == ST_CLEAR) || (state_q == ST_WR);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : ins_addr;
	assign wr_data = (state_q == ST_CLEAR) ? '0 :
	                 ((rdata_q == CNT_TOP) ? rdata_q : rdata_q + 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bin_mem[wr_addr] <= wr_data;
		end
		rdata_q <= bin_mem[rd_addr];
	end

	// Per-code accumulators rotate so that the code being read sits at the head.
	logic [CSUM_W-1:0]     sum_rot_q [NUM_CODES];
	logic [COUNT_BITS-1:0] max_rot_q [NUM_CODES];
	logic [TSUM_W-1:0]     total_q;
	logic [CSUM_W:0]       sum_add;
	logic [CSUM_W-1:0]     sum_new;
	logic [COUNT_BITS-1:0] max_new;
	logic [TSUM_W:0]       tot_add;
	logic [KW-1:0]         oidx_q;
	logic                  rep_start;
	logic                  out_acc;
	logic                  rotate;

	assign sum_add   = (CSUM_W + 1)'(sum_rot_q[0]) + (CSUM_W + 1)'(rdata_q);
	assign sum_new   = sum_add[CSUM_W] ? '1 : sum_add[CSUM_W-1:0];
	assign max_new   = (rdata_q > max_rot_q[0]) ? rdata_q : max_rot_q[0];
	assign tot_add   = (TSUM_W + 1)'(total_q) + (TSUM_W + 1)'(rdata_q);
	assign rep_start = acc_in && (op == OP_REPORT);
	assign out_acc   = out_valid && out_ready;
	assign rotate    = v_s1 || (out_acc && (state_q == ST_REP));

	always_ff @(posedge clk) begin
		if (rep_start) begin
			for (int i = 0; i < NUM_CODES; i++) begin
				sum_rot_q[i] <= '0;
				max_rot_q[i] <= '0;
			end
			total_q <= '0;
		end else if (rotate) begin
			for (int i = 0; i < NUM_CODES - 1; i++) begin
				sum_rot_q[i] <= sum_rot_q[i+1];
				max_rot_q[i] <= max_rot_q[i+1];
			end
			sum_rot_q[NUM_CODES-1] <= v_s1 ? sum_new : sum_rot_q[0];
			max_rot_q[NUM_CODES-1] <= v_s1 ? max_new : max_rot_q[0];
			if (v_s1) begin
				total_q <= tot_add[TSUM_W] ? '1 : tot_add[TSUM_W-1:0];
			end
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			k_q        <= '0;
			c_q        <= '0;
			r_q        <= '0;
			pix_base_q <= '0;
			row_base_q <= '0;
			v_s1       <= 1'b0;
			oidx_q     <= '0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						k_q        <= '0;
						c_q        <= '0;
						r_q        <= '0;
						pix_base_q <= '0;
						row_base_q <= '0;
						oidx_q     <= '0;
						if (op == OP_INSERT) begin
							state_q <= ST_DIV;
						end else if (w_eff == '0 || h_eff == '0) begin
							state_q <= ST_REP;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_DIV: begin
					if (res_x.done && res_y.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= chk_ok ? ST_RD : ST_ACK;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (32'(k_q) == NUM_CODES - 1) begin
						k_q <= '0;
						if (c_q == CW'(w_eff - 1'b1)) begin
							c_q        <= '0;
							r_q        <= r_q + 1'b1;
							row_base_q <= AW'(row_base_q + AW'(ROW_STRIDE));
							pix_base_q <= AW'(row_base_q + AW'(ROW_STRIDE));
						end else begin
							c_q        <= c_q + 1'b1;
							pix_base_q <= AW'(pix_base_q + AW'(NUM_CODES));
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
					if (sweep_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_REP;
				end
				ST_REP: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 1'b1;
						if (32'(oidx_q) == NUM_CODES - 1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result fields.
	logic [2*CW+2*RW-1:0] npix;
	logic                 rep;
	logic                 ack;

	assign npix = (2*CW + 2*RW)'(w_eff) * (2*CW + 2*RW)'(h_eff);
	assign rep  = (state_q == ST_REP);
	assign ack  = (state_q == ST_ACK);

	assign out_valid   = ack || rep;
	assign kind        = rep ? KIND_REPORT : KIND_ACK;
	assign accepted    = ack && ok_q;
	assign row         = (ack && ok_q) ? IDX_W'(32'(row_q)) : '0;
	assign col         = (ack && ok_q) ? IDX_W'(32'(col_q)) : '0;
	assign report_code = rep ? CODE_W'(32'(oidx_q)) : '0;
	assign code_sum    = rep ? sum_rot_q[0] : '0;
	assign code_max    = !rep ? '0 :
	                     ((33'(max_rot_q[0]) > 33'(16'hFFFF)) ? '1 : CMAX_W'(max_rot_q[0]));
	assign total_sum   = rep ? total_q : '0;
	assign pixel_count = !rep ? '0 :
	                     ((32'(npix) > 32'(13'h1FFF)) ? '1 : PIX_W'(npix));
	assign last        = ack || (rep && (32'(oidx_q) == NUM_CODES - 1));

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (res_x.done == res_y.done))
		else $error("dividers out of step");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ACK && !accepted) |-> (row == '0 && col == '0))
		else $error("rejected insert carries a bin index");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD))
		else $error("bin write-back without a read");
`endif

endmodule
